FILE: sv/tspmt_pkg.sv
// tspmt_pkg: shared constants, status codes and the CRC byte step for the
// PMT section parser. No dependencies.
`timescale 1ns / 1ps

package tspmt_pkg;

    localparam int MAX_SECTION_BYTES_DEF = 1024;
    localparam int PID_W      = 13;
    localparam int STATUS_W   = 3;
    localparam int ENTRY_W    = 14;
    localparam int POS_W      = 13;

    localparam logic [7:0]  TABLE_ID_PMT = 8'h02;
    localparam logic [7:0]  TAG_CA       = 8'h09;
    localparam logic [12:0] PID_NULL     = 13'h1fff;
    localparam logic [31:0] CRC_POLY     = 32'h04C11DB7;
    localparam logic [31:0] CRC_INIT     = 32'hFFFFFFFF;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_SHORT    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_SYNTAX   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_TABLE_ID = 3'd3;
    localparam logic [STATUS_W-1:0] ST_LENGTH   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_CRC      = 3'd5;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd6;

    // one byte through CRC-32/MPEG-2, MSB first
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                             input logic [7:0]  data);
        logic [31:0] c;
        c = crc_in ^ {data, 24'd0};
        for (int b = 0; b < 8; b++) begin
            c = c[31] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

FILE: sv/ts_pmt_section_parser.sv
// ts_pmt_section_parser: MPEG-2 TS PMT section checker and PID table.
// Depends on tspmt_pkg.
`timescale 1ns / 1ps

// Section bytes (op 0) are taken one per cycle while the parser is idle and
// written to the section memory while a running CRC and the first twelve
// header bytes are kept in flops. The marked last byte starts a pass that
// clears the 8192-entry PID table, one entry per cycle, then checks the
// section from registers and, when it passes, walks the descriptor and
// elementary-stream loops out of the section memory. The walk is paced by
// the single read port of that memory: a descriptor header reads its
// tag and length, a CA PID two more bytes, a stream entry header its
// type, PID and info length bytes, and a table insert reads, then writes
// the PID entry. A lookup (op 1) reads the table, and its result goes
// to the output register. After reset the same clearing pass runs before
// the first transaction is taken. Results go through an output register,
// so section bytes keep flowing while a result waits downstream.
module ts_pmt_section_parser #(
    parameter int MAX_SECTION_BYTES = tspmt_pkg::MAX_SECTION_BYTES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_op,
    input  logic [7:0]                        i_data_byte,
    input  logic                              i_last_byte,
    input  logic [tspmt_pkg::PID_W-1:0]       i_query_pid,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [tspmt_pkg::STATUS_W-1:0]    o_status,
    output logic [15:0]                       o_prog_num,
    output logic [4:0]                        o_version,
    output logic                              o_current_next,
    output logic [7:0]                        o_sect_num,
    output logic [7:0]                        o_last_sect_num,
    output logic [15:0]                       o_pcr_pid,
    output logic [tspmt_pkg::ENTRY_W-1:0]     o_entry_count,
    output logic                              o_pid_present,
    output logic [7:0]                        o_pid_stream_type
);
    import tspmt_pkg::*;

    localparam int AW = $clog2(MAX_SECTION_BYTES);
    localparam int CW = $clog2(MAX_SECTION_BYTES + 1);
    localparam int PID_SPACE = 1 << PID_W;

    typedef enum logic [4:0] {
        S_IDLE, S_CLEAR, S_CHECK, S_D_HEAD, S_D_T, S_D_L, S_D_C1, S_D_C2,
        S_E_HEAD, S_E0, S_E1, S_E2, S_E3, S_E4, S_INS_RD, S_INS_WR,
        S_LOOKUP, S_EMIT
    } t_state;

    // memories
    logic [7:0] r_sec_mem [MAX_SECTION_BYTES];
    logic [8:0] r_tbl_mem [PID_SPACE];
    logic [7:0] r_sec_rd;
    logic [8:0] r_tbl_rd;

    t_state            r_state;
    logic              r_boot;
    logic [PID_W-1:0]  r_clr;
    logic [CW-1:0]     r_count;
    logic              r_ovf;
    logic [31:0]       r_crc;
    logic [7:0]        r_hdr [12];
    logic [ENTRY_W-1:0] r_entries;
    logic [15:0]       r_program;
    logic [15:0]       r_pcr;
    logic [4:0]        r_version;
    logic              r_curnext;
    logic [7:0]        r_secnum;
    logic [7:0]        r_lastsec;
    logic [POS_W-1:0]  r_pos;
    logic [POS_W-1:0]  r_done;
    logic [11:0]       r_len;
    logic [11:0]       r_end;
    logic [7:0]        r_tag;
    logic [7:0]        r_dlen;
    logic [4:0]        r_hi;
    logic [3:0]        r_esh;
    logic [7:0]        r_st;
    logic [PID_W-1:0]  r_ins_pid;
    logic [7:0]        r_ins_type;
    logic [STATUS_W-1:0] r_status;
    logic              r_lk_present;
    logic [7:0]        r_lk_type;

    logic              w_accept;
    logic              w_store;
    logic [POS_W-1:0]  w_sec_pos;
    logic [PID_W-1:0]  w_tbl_raddr;
    logic              w_tbl_we;
    logic [PID_W-1:0]  w_tbl_waddr;
    logic [8:0]        w_tbl_wdata;
    logic [11:0]       w_slen;
    logic [13:0]       w_crc_lim;
    logic [13:0]       w_newpos;
    logic              w_out_free;
    logic [STATUS_W-1:0] w_chk;

    assign o_stall    = (r_state != S_IDLE);
    assign w_accept   = i_valid && !o_stall;
    assign w_store    = w_accept && !i_op && (r_count < CW'(MAX_SECTION_BYTES));
    assign w_slen     = {r_hdr[1][3:0], r_hdr[2]};
    assign w_crc_lim  = 14'd3 + {2'd0, w_slen};
    assign w_newpos   = {1'b0, r_pos} + 14'd2;
    assign w_out_free = !o_valid || !i_stall;

    // section memory read address per walk state
    always_comb begin
        unique case (r_state)
            S_D_T, S_E0: w_sec_pos = r_pos + POS_W'(1);
            S_E1:        w_sec_pos = r_pos + POS_W'(2);
            S_D_C1, S_E2: w_sec_pos = r_pos + POS_W'(3);
            S_D_L, S_E3: w_sec_pos = r_pos + POS_W'(4);
            default:     w_sec_pos = r_pos;
        endcase
    end

    always_comb begin
        w_tbl_raddr = (r_state == S_IDLE) ? i_query_pid : r_ins_pid;
        w_tbl_we    = 1'b0;
        w_tbl_waddr = r_ins_pid;
        w_tbl_wdata = {1'b1, r_ins_type};
        if (r_state == S_CLEAR) begin
            w_tbl_we    = 1'b1;
            w_tbl_waddr = r_clr;
            w_tbl_wdata = 9'd0;
        end else if (r_state == S_INS_WR && !r_tbl_rd[8]) begin
            w_tbl_we    = 1'b1;
        end
    end

    // section checks, in priority order
    always_comb begin
        priority if (r_ovf)                          w_chk = ST_OVERFLOW;
        else if (r_count < CW'(7))                   w_chk = ST_SHORT;
        else if (!r_hdr[1][7])                       w_chk = ST_SYNTAX;
        else if (r_hdr[0] != TABLE_ID_PMT)           w_chk = ST_TABLE_ID;
        else if (w_crc_lim > 14'(r_count) || w_slen < 12'd4) w_chk = ST_LENGTH;
        else if (r_crc != 32'd0)                     w_chk = ST_CRC;
        else                                         w_chk = ST_OK;
    end

    always_ff @(posedge i_clk) begin
        if (w_store) begin
            r_sec_mem[r_count[AW-1:0]] <= i_data_byte;
        end
        r_sec_rd <= r_sec_mem[w_sec_pos[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (w_tbl_we) begin
            r_tbl_mem[w_tbl_waddr] <= w_tbl_wdata;
        end
        r_tbl_rd <= r_tbl_mem[w_tbl_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_boot    <= 1'b1;
            r_clr     <= '0;
            r_count   <= '0;
            r_ovf     <= 1'b0;
            r_crc     <= CRC_INIT;
            r_entries <= '0;
            r_program <= 16'hFFFF;
            r_pcr     <= 16'hFFFF;
            r_version <= '0;
            r_curnext <= 1'b0;
            r_secnum  <= '0;
            r_lastsec <= '0;
            o_valid   <= 1'b0;
        end else begin
            // S_EMIT reloads the output register itself
            if (o_valid && !i_stall && r_state != S_EMIT) begin
                o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept && i_op) begin
                        r_state <= S_LOOKUP;
                    end else if (w_accept) begin
                        if (w_store) begin
                            r_count <= r_count + CW'(1);
                            if (r_count < CW'(3) || 14'(r_count) < w_crc_lim) begin
                                r_crc <= crc_byte(r_crc, i_data_byte);
                            end
                            if (r_count < CW'(12)) begin
                                r_hdr[r_count[3:0]] <= i_data_byte;
                            end
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (i_last_byte) begin
                            r_lk_present <= 1'b0;
                            r_lk_type    <= '0;
                            r_clr        <= '0;
                            r_entries    <= '0;
                            r_state      <= S_CLEAR;
                        end
                    end
                end
                S_CLEAR: begin
                    r_clr <= r_clr + PID_W'(1);
                    if (r_clr == PID_W'(PID_SPACE - 1)) begin
                        r_boot  <= 1'b0;
                        r_state <= r_boot ? S_IDLE : S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_count  <= '0;
                    r_ovf    <= 1'b0;
                    r_crc    <= CRC_INIT;
                    r_status <= w_chk;
                    if (w_chk == ST_OK && w_slen > 12'd12) begin
                        r_program <= {r_hdr[3], r_hdr[4]};
                        r_version <= r_hdr[5][5:1];
                        r_curnext <= r_hdr[5][0];
                        r_secnum  <= r_hdr[6];
                        r_lastsec <= r_hdr[7];
                        r_pcr     <= {3'd0, r_hdr[8][4:0], r_hdr[9]};
                        r_len     <= {r_hdr[10][3:0], r_hdr[11]};
                        r_end     <= w_slen - 12'd1;
                        r_pos     <= POS_W'(12);
                        r_done    <= '0;
                        r_state   <= S_D_HEAD;
                    end else begin
                        r_state   <= S_EMIT;
                    end
                end
                // descriptor loop
                S_D_HEAD: begin
                    if ({1'b0, r_pos} + 14'd1 < {2'd0, r_end} &&
                        r_done < {1'b0, r_len}) begin
                        r_state <= S_D_T;
                    end else begin
                        r_state <= S_E_HEAD;
                    end
                end
                S_D_T: begin
                    r_tag   <= r_sec_rd;
                    r_state <= S_D_L;
                end
                S_D_L: begin
                    r_dlen <= r_sec_rd;
                    r_done <= r_done + POS_W'(2) + POS_W'(r_sec_rd);
                    if (r_tag == TAG_CA && r_sec_rd >= 8'd4 &&
                        w_newpos + 14'd3 < {2'd0, r_end}) begin
                        r_pos   <= w_newpos[POS_W-1:0];
                        r_state <= S_D_C1;
                    end else begin
                        r_pos   <= w_newpos[POS_W-1:0] + POS_W'(r_sec_rd);
                        r_state <= S_D_HEAD;
                    end
                end
                S_D_C1: begin
                    r_hi    <= r_sec_rd[4:0];
                    r_state <= S_D_C2;
                end
                S_D_C2: begin
                    r_pos <= r_pos + POS_W'(r_dlen);
                    if ({r_hi, r_sec_rd} != PID_NULL) begin
                        r_ins_pid  <= {r_hi, r_sec_rd};
                        r_ins_type <= '0;
                        r_state    <= S_INS_RD;
                    end else begin
                        r_state    <= S_D_HEAD;
                    end
                end
                // elementary stream loop
                S_E_HEAD: begin
                    if ({1'b0, r_pos} + 14'd4 < {2'd0, r_end}) begin
                        r_state <= S_E0;
                    end else begin
                        r_status <= ST_OK;
                        r_state  <= S_EMIT;
                    end
                end
                S_E0: begin
                    r_st    <= r_sec_rd;
                    r_state <= S_E1;
                end
                S_E1: begin
                    r_hi    <= r_sec_rd[4:0];
                    r_state <= S_E2;
                end
                S_E2: begin
                    r_ins_pid <= {r_hi, r_sec_rd};
                    r_state   <= S_E3;
                end
                S_E3: begin
                    r_esh   <= r_sec_rd[3:0];
                    r_state <= S_E4;
                end
                S_E4: begin
                    r_len      <= {r_esh, r_sec_rd};
                    r_done     <= '0;
                    r_pos      <= r_pos + POS_W'(5);
                    r_ins_type <= r_st;
                    r_state    <= S_INS_RD;
                end
                // table insert: first one wins
                S_INS_RD: begin
                    r_state <= S_INS_WR;
                end
                S_INS_WR: begin
                    if (!r_tbl_rd[8]) begin
                        r_entries <= r_entries + ENTRY_W'(1);
                    end
                    r_state <= S_D_HEAD;
                end
                S_LOOKUP: begin
                    r_status     <= ST_OK;
                    r_lk_present <= r_tbl_rd[8];
                    r_lk_type    <= r_tbl_rd[8] ? r_tbl_rd[7:0] : 8'd0;
                    r_state      <= S_EMIT;
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        o_valid           <= 1'b1;
                        o_status          <= r_status;
                        o_prog_num        <= r_program;
                        o_version         <= r_version;
                        o_current_next    <= r_curnext;
                        o_sect_num        <= r_secnum;
                        o_last_sect_num   <= r_lastsec;
                        o_pcr_pid         <= r_pcr;
                        o_entry_count     <= r_entries;
                        o_pid_present     <= r_lk_present;
                        o_pid_stream_type <= r_lk_type;
                        r_state           <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
